// ===== sv/proto_route_table_with_aging_assert.svh =====
// Assertion macros for the route table RTL.
// Depends on a clock named clk and an active-low reset named arst_n in the user's scope.
`ifndef PROTO_ROUTE_TABLE_WITH_AGING_ASSERT_SVH
`define PROTO_ROUTE_TABLE_WITH_AGING_ASSERT_SVH

// The consequent must hold in the same cycle as the antecedent.
`define PRT_ASSERT_NOW(label, ante, cons, msg) \
	label: assert property (@(posedge clk) disable iff (!arst_n) (ante) |-> (cons)) \
		else $error(msg);

// The consequent must hold in the cycle after the antecedent.
`define PRT_ASSERT_NEXT(label, ante, cons, msg) \
	label: assert property (@(posedge clk) disable iff (!arst_n) (ante) |=> (cons)) \
		else $error(msg);

`endif

// ===== sv/prt_pkg.sv =====
// Types and codes for the protocol route table.
// No dependencies; used by prt_cell and proto_route_table_with_aging.
package prt_pkg;

	localparam int unsigned KEY_W   = 8;
	localparam int unsigned STACK_W = 8;
	localparam int unsigned AGE_W   = 8;

	typedef logic [1:0] op_t;
	typedef logic [1:0] status_t;

	localparam op_t OP_INSERT = 2'd0;
	localparam op_t OP_FIND   = 2'd1;
	localparam op_t OP_AGE    = 2'd2;

	localparam status_t STAT_OK        = 2'd0;
	localparam status_t STAT_NOT_FOUND = 2'd1;
	localparam status_t STAT_FULL      = 2'd2;

	localparam logic [AGE_W-1:0] MAX_AGE_RESET = 8'd3;

	typedef struct packed {
		op_t                operation;
		logic [KEY_W-1:0]   proto_key;
		logic [STACK_W-1:0] stack_in;
	} req_t;

	typedef struct packed {
		status_t            status;
		logic [STACK_W-1:0] stack_out;
	} rsp_t;

	// Running state handed from one cell to the next, lowest entry first.
	typedef struct packed {
		logic               hit;
		logic               free;
		logic [STACK_W-1:0] stack;
	} link_t;

	typedef enum logic {
		S_IDLE,
		S_EXEC
	} state_t;

endpackage

// ===== sv/proto_route_table_with_aging.sv =====
// Top level of the protocol route table: command register, chain of entry cells, result register.
// Depends on prt_pkg, prt_cell and proto_route_table_with_aging_assert.svh.
//
//  channel | signals                          | payload
//  --------+----------------------------------+-------------------------------
//  in      | in_valid / in_ready              | in_data  (operation, key, stack)
//  out     | out_valid / out_ready            | out_data (status, stack_out)
//  cfg     | cfg_we                           | cfg_wdata (max_age)
//
// Each word is first captured; then, in the execute state, every cell compares its key
// and the hit/free priority chain ripples from entry 0 to the last entry before commit.
// The result then sits in an output register; a new word is taken once the result is
// registered, even if the previous result has not yet been taken.
// A stalled output holds the command in its execute state until the register frees up.
// Reset clears all valid flags at once and sets max_age to 3.
module proto_route_table_with_aging #(
	parameter int unsigned ENTRIES = 16
) (
	input  logic                          clk,
	input  logic                          arst_n,
	input  logic                          in_valid,
	output logic                          in_ready,
	input  prt_pkg::req_t                 in_data,
	output logic                          out_valid,
	input  logic                          out_ready,
	output prt_pkg::rsp_t                 out_data,
	input  logic                          cfg_we,
	input  logic [prt_pkg::AGE_W-1:0]     cfg_wdata
);

	`include "proto_route_table_with_aging_assert.svh"

	prt_pkg::state_t               state_q;
	prt_pkg::state_t               state_nxt;
	prt_pkg::req_t                 cmd_s1;
	logic [prt_pkg::AGE_W-1:0]     max_age_q;
	logic                          out_valid_q;
	prt_pkg::rsp_t                 out_data_q;
	prt_pkg::rsp_t                 rsp;
	logic                          accept;
	logic                          advance;
	prt_pkg::link_t                links [ENTRIES+1];

	assign accept  = in_valid && in_ready;
	assign advance = (state_q == prt_pkg::S_EXEC) && (!out_valid_q || out_ready);

	always_comb begin
		state_nxt = state_q;
		in_ready  = 1'b0;
		unique case (state_q)
			prt_pkg::S_IDLE: begin
				in_ready = 1'b1;
				if (in_valid) begin
					state_nxt = prt_pkg::S_EXEC;
				end
			end
			prt_pkg::S_EXEC: begin
				if (advance) begin
					state_nxt = prt_pkg::S_IDLE;
				end
			end
			default: begin
				state_nxt = prt_pkg::S_IDLE;
			end
		endcase
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q <= prt_pkg::S_IDLE;
		end else begin
			state_q <= state_nxt;
		end
	end

	always_ff @(posedge clk) begin
		if (accept) begin
			cmd_s1 <= in_data;
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			max_age_q <= prt_pkg::MAX_AGE_RESET;
		end else if (cfg_we) begin
			max_age_q <= cfg_wdata;
		end
	end

	assign links[0] = '0;

	for (genvar i = 0; i < ENTRIES; i++) begin : g_cell
		prt_cell u_cell (
			.clk      (clk),
			.arst_n   (arst_n),
			.cmd      (cmd_s1),
			.max_age  (max_age_q),
			.commit   (advance),
			.any_hit  (links[ENTRIES].hit),
			.link_in  (links[i]),
			.link_out (links[i+1])
		);
	end

	always_comb begin
		rsp.status    = prt_pkg::STAT_OK;
		rsp.stack_out = '0;
		case (cmd_s1.operation)
			prt_pkg::OP_INSERT: begin
				if (!links[ENTRIES].hit && !links[ENTRIES].free) begin
					rsp.status = prt_pkg::STAT_FULL;
				end
			end
			prt_pkg::OP_FIND: begin
				if (links[ENTRIES].hit) begin
					rsp.stack_out = links[ENTRIES].stack;
				end else begin
					rsp.status = prt_pkg::STAT_NOT_FOUND;
				end
			end
			default: begin
			end
		endcase
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			out_valid_q <= 1'b0;
		end else if (advance) begin
			out_valid_q <= 1'b1;
		end else if (out_ready) begin
			out_valid_q <= 1'b0;
		end
	end

	always_ff @(posedge clk) begin
		if (advance) begin
			out_data_q <= rsp;
		end
	end

	assign out_valid = out_valid_q;
	assign out_data  = out_data_q;

	`PRT_ASSERT_NEXT(a_accept_exec, accept, state_q == prt_pkg::S_EXEC, "accepted word did not enter execute")
	`PRT_ASSERT_NEXT(a_exec_result, advance, out_valid_q, "executed word produced no result")
	`PRT_ASSERT_NOW(a_miss_zero, out_valid_q && (out_data_q.status == prt_pkg::STAT_NOT_FOUND), out_data_q.stack_out == '0, "miss carries a nonzero stack id")

endmodule

// ===== sv/prt_cell.sv =====
// One table entry: valid flag, key, stack id and age, plus its link in the priority chain.
// Depends on prt_pkg.
module prt_cell (
	input  logic                         clk,
	input  logic                         arst_n,
	input  prt_pkg::req_t                cmd,
	input  logic [prt_pkg::AGE_W-1:0]    max_age,
	input  logic                         commit,
	input  logic                         any_hit,
	input  prt_pkg::link_t               link_in,
	output prt_pkg::link_t               link_out
);

	logic                           valid_q;
	logic [prt_pkg::KEY_W-1:0]      key_q;
	logic [prt_pkg::STACK_W-1:0]    stack_q;
	logic [prt_pkg::AGE_W-1:0]      age_q;

	logic match;
	logic hit_here;
	logic claim_free;
	logic refresh;
	logic fill;
	logic age_tick;

	assign match      = valid_q && (key_q == cmd.proto_key);
	assign hit_here   = match && !link_in.hit;
	assign claim_free = !valid_q && !link_in.free;

	assign link_out.hit   = link_in.hit | match;
	assign link_out.free  = link_in.free | !valid_q;
	assign link_out.stack = link_in.stack | (hit_here ? stack_q : '0);

	always_comb begin
		refresh  = 1'b0;
		fill     = 1'b0;
		age_tick = 1'b0;
		unique case (cmd.operation)
			prt_pkg::OP_INSERT: begin
				refresh = commit && hit_here;
				fill    = commit && !any_hit && claim_free;
			end
			prt_pkg::OP_AGE: begin
				age_tick = commit && valid_q;
			end
			default: begin
			end
		endcase
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			valid_q <= 1'b0;
		end else if (fill) begin
			valid_q <= 1'b1;
		end else if (age_tick && (age_q == '0)) begin
			valid_q <= 1'b0;
		end
	end

	always_ff @(posedge clk) begin
		if (fill) begin
			key_q <= cmd.proto_key;
		end
		if (fill || refresh) begin
			stack_q <= cmd.stack_in;
			age_q   <= max_age;
		end else if (age_tick && (age_q != '0)) begin
			age_q <= age_q - prt_pkg::AGE_W'(1);
		end
	end

endmodule

// ===== tb/sv/tb_top.sv =====
// Self-checking testbench for the protocol route table with aging.
// Depends on prt_pkg and the proto_route_table_with_aging RTL; needs no files or arguments.
// A shadow copy of the table predicts every result, and a small class checks results in order.
module tb_top;
	timeunit 1ns;
	timeprecision 1ps;

	localparam int ENTRIES = 16;
	localparam int CYCLE_LIMIT = 200000;
	localparam int WORDS_PER_PHASE = 140;
	localparam int HOLD_AFTER_WORDS = 200;
	localparam int HOLD_CYCLES = 300;
	// The block ignores this operation code and answers with a plain success.
	localparam prt_pkg::op_t OP_UNUSED = 2'd3;

	// Shadow of the table contents; it predicts one response per accepted request word.
	class route_table_shadow;
		logic [prt_pkg::AGE_W-1:0]   max_age;
		bit                          valid [ENTRIES];
		logic [prt_pkg::KEY_W-1:0]   key [ENTRIES];
		logic [prt_pkg::STACK_W-1:0] stack [ENTRIES];
		logic [prt_pkg::AGE_W-1:0]   age [ENTRIES];
		prt_pkg::rsp_t               expected_rsp [$];
		int                          errors;

		function new();
			max_age = prt_pkg::MAX_AGE_RESET;
			errors = 0;
			foreach (valid[i]) valid[i] = 1'b0;
		endfunction

		function int lookup(logic [prt_pkg::KEY_W-1:0] k);
			for (int i = 0; i < ENTRIES; i++) begin
				if (valid[i] && key[i] == k) return i;
			end
			return -1;
		endfunction

		function void apply_word(prt_pkg::req_t w);
			prt_pkg::rsp_t r;
			int slot;
			r.status = prt_pkg::STAT_OK;
			r.stack_out = '0;
			case (w.operation)
				prt_pkg::OP_INSERT: begin
					slot = lookup(w.proto_key);
					if (slot < 0) begin
						for (int i = ENTRIES - 1; i >= 0; i--) begin
							if (!valid[i]) slot = i;
						end
						if (slot >= 0) begin
							valid[slot] = 1'b1;
							key[slot] = w.proto_key;
						end
					end
					if (slot >= 0) begin
						stack[slot] = w.stack_in;
						age[slot] = max_age;
					end else begin
						r.status = prt_pkg::STAT_FULL;
					end
				end
				prt_pkg::OP_FIND: begin
					slot = lookup(w.proto_key);
					if (slot >= 0) r.stack_out = stack[slot];
					else r.status = prt_pkg::STAT_NOT_FOUND;
				end
				prt_pkg::OP_AGE: begin
					for (int i = 0; i < ENTRIES; i++) begin
						if (valid[i]) begin
							if (age[i] == '0) valid[i] = 1'b0;
							else age[i] = age[i] - 8'd1;
						end
					end
				end
				default: ;
			endcase
			expected_rsp.push_back(r);
		endfunction

		function void note_mismatch(string what, logic [7:0] want, logic [7:0] got);
			errors++;
			if (errors <= 10)
				$display("%0t: %s mismatch: expected %0h, got %0h", $realtime, what, want, got);
		endfunction

		function void compare_word(prt_pkg::rsp_t got);
			prt_pkg::rsp_t want;
			if (expected_rsp.size() == 0) begin
				errors++;
				if (errors <= 10)
					$display("%0t: response word with nothing outstanding: status %0h stack %0h",
						$realtime, got.status, got.stack_out);
				return;
			end
			want = expected_rsp.pop_front();
			if (got.status !== want.status)
				note_mismatch("status", 8'(want.status), 8'(got.status));
			if (got.stack_out !== want.stack_out)
				note_mismatch("stack_out", want.stack_out, got.stack_out);
		endfunction

		function int pending();
			return expected_rsp.size();
		endfunction
	endclass

	logic                       clk = 1'b0;
	logic                       arst_n = 1'b0;
	logic                       in_valid = 1'b0;
	logic                       in_ready;
	prt_pkg::req_t              in_data = '0;
	logic                       out_valid;
	logic                       out_ready = 1'b0;
	prt_pkg::rsp_t              out_data;
	logic                       cfg_we = 1'b0;
	logic [prt_pkg::AGE_W-1:0]  cfg_wdata = '0;

	route_table_shadow shadow = new();
	int                n_accepted = 0;
	int                cycles = 0;
	bit                idle_on = 1'b1;

	proto_route_table_with_aging #(
		.ENTRIES(ENTRIES)
	) u_top (
		.clk(clk),
		.arst_n(arst_n),
		.in_valid(in_valid),
		.in_ready(in_ready),
		.in_data(in_data),
		.out_valid(out_valid),
		.out_ready(out_ready),
		.out_data(out_data),
		.cfg_we(cfg_we),
		.cfg_wdata(cfg_wdata)
	);

	always begin
		#5 clk = 1'b1;
		#5 clk = 1'b0;
	end

	// All handshakes are observed here on pre-edge values, so process order does not matter.
	always @(posedge clk) begin
		if (cfg_we) shadow.max_age = cfg_wdata;
		if (in_valid && in_ready) begin
			shadow.apply_word(in_data);
			n_accepted++;
		end
		if (out_valid && out_ready) shadow.compare_word(out_data);
	end

	always @(posedge clk) begin
		cycles++;
		if (cycles > CYCLE_LIMIT) begin
			$display("Testbench completed WITH ERRORS");
			$finish;
		end
	end

	// Result side: random stalls, plus one long hold-off so the block backs up into its input.
	initial begin
		int hold_left;
		bit hold_done;
		hold_left = 0;
		hold_done = 1'b0;
		forever begin
			@(posedge clk);
			if (!hold_done && n_accepted >= HOLD_AFTER_WORDS) begin
				hold_left = HOLD_CYCLES;
				hold_done = 1'b1;
			end
			if (hold_left > 0) begin
				out_ready <= 1'b0;
				hold_left--;
			end else begin
				out_ready <= !(idle_on && $urandom_range(99) < 30);
			end
		end
	end

	task automatic offer_word(input prt_pkg::req_t w);
		while (idle_on && $urandom_range(99) < 30) begin
			in_valid <= 1'b0;
			@(posedge clk);
		end
		in_valid <= 1'b1;
		in_data <= w;
		@(posedge clk);
		while (!in_ready) @(posedge clk);
	endtask

	// Waits until every response is back and the pipeline has surely emptied.
	task automatic wait_all_results();
		in_valid <= 1'b0;
		@(posedge clk);
		while (shadow.pending() != 0) @(posedge clk);
		repeat (4) @(posedge clk);
	endtask

	task automatic write_max_age(input logic [prt_pkg::AGE_W-1:0] value);
		wait_all_results();
		cfg_we <= 1'b1;
		cfg_wdata <= value;
		@(posedge clk);
		cfg_we <= 1'b0;
	endtask

	initial begin
		logic [prt_pkg::AGE_W-1:0] age_plan [6];
		logic [prt_pkg::KEY_W-1:0] pool_base;
		int                        pick;
		prt_pkg::req_t             w;

		repeat (3) @(posedge clk);
		arst_n <= 1'b1;
		@(posedge clk);
		write_max_age(8'd2);

		// Empty table, unused code, both key extremes, refresh, then fill to overflow.
		offer_word('{prt_pkg::OP_FIND, 8'h00, 8'h00});
		offer_word('{prt_pkg::OP_AGE, 8'hFF, 8'hFF});
		offer_word('{OP_UNUSED, 8'h5A, 8'hC3});
		offer_word('{prt_pkg::OP_INSERT, 8'h00, 8'hFF});
		offer_word('{prt_pkg::OP_INSERT, 8'hFF, 8'h00});
		offer_word('{prt_pkg::OP_FIND, 8'hFF, 8'h00});
		offer_word('{prt_pkg::OP_FIND, 8'h00, 8'h00});
		offer_word('{prt_pkg::OP_INSERT, 8'h00, 8'hA5});
		offer_word('{prt_pkg::OP_FIND, 8'h00, 8'h00});
		for (int i = 0; i < ENTRIES - 2; i++)
			offer_word('{prt_pkg::OP_INSERT, 8'h10 + 8'(i), 8'($urandom)});
		offer_word('{prt_pkg::OP_INSERT, 8'h7E, 8'h11});
		offer_word('{prt_pkg::OP_INSERT, 8'hFF, 8'h3C});

		age_plan = '{8'd255, 8'd0, 8'd1, 8'd3, 8'd128, 8'($urandom_range(2, 254))};
		for (int p = 0; p < 6; p++) begin
			write_max_age(age_plan[p]);
			idle_on = (p != 2);
			pool_base = 8'($urandom);
			repeat (WORDS_PER_PHASE) begin
				// Keys mostly come from a pool a bit larger than the table, so hits,
				// refreshes, expiry and a full table all happen often.
				pick = $urandom_range(99);
				if (pick < 40) w.operation = prt_pkg::OP_INSERT;
				else if (pick < 75) w.operation = prt_pkg::OP_FIND;
				else if (pick < 95) w.operation = prt_pkg::OP_AGE;
				else w.operation = OP_UNUSED;
				if ($urandom_range(99) < 85) w.proto_key = pool_base ^ 8'($urandom_range(23));
				else w.proto_key = 8'($urandom);
				w.stack_in = 8'($urandom);
				offer_word(w);
			end
		end

		wait_all_results();
		repeat (20) @(posedge clk);
		if (shadow.errors == 0 && shadow.pending() == 0) begin
			$display("Testbench completed without errors");
		end else begin
			$display("Testbench completed WITH ERRORS");
		end
		$finish;
	end
endmodule

// ===== proto_route_table_with_aging.f =====
+incdir+sv
sv/prt_pkg.sv
sv/prt_cell.sv
sv/proto_route_table_with_aging.sv
tb/sv/tb_top.sv
